### src/irpd_pkg.sv
// Shared constants, codes and types of the IR pulse-distance transmitter.
package irpd_pkg;

  // Field widths and store geometry; the 3-bit slot index sets eight slots.
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned NUM_SLOTS = 1 << SLOT_W;
  localparam int unsigned POS_W     = SLOT_W + 1;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned BIT_SEL_W = $clog2(DATA_W);
  localparam int unsigned SIZE_W    = 6;
  localparam int unsigned HALF_W    = 6;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // Commands
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVENT = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARK         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = 3'd4;

  // Register reset values
  localparam logic [TICK_W-1:0]  RST_HEADER_SPACE = 16'd4500;
  localparam logic [TICK_W-1:0]  RST_MARK         = 16'd560;
  localparam logic [TICK_W-1:0]  RST_ONE_SPACE    = 16'd1690;
  localparam logic [TICK_W-1:0]  RST_ZERO_SPACE   = 16'd560;
  localparam logic [COUNT_W-1:0] RST_ENTRY_COUNT  = 4'd0;

  // Result phase codes
  localparam logic [PHASE_W-1:0] PHASE_HEADER_SPACE = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_BIT_MARK     = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_ONE_SPACE    = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_ZERO_SPACE   = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_TRAIL_MARK   = 3'd4;
  localparam logic [PHASE_W-1:0] PHASE_STOP         = 3'd5;

  typedef enum logic [2:0] {
    TX_IDLE,
    TX_LEADER,
    TX_DATA,
    TX_END,
    TX_COOLDOWN
  } tx_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] entry_index;
    logic [DATA_W-1:0] entry_data;
    logic [SIZE_W-1:0] entry_size;
  } item_t;

  typedef struct packed {
    logic [TICK_W-1:0]  interval_ticks;
    logic [PHASE_W-1:0] phase;
    logic               finished;
  } result_t;

  typedef struct packed {
    logic [TICK_W-1:0]  header_space_ticks;
    logic [TICK_W-1:0]  mark_ticks;
    logic [TICK_W-1:0]  one_space_ticks;
    logic [TICK_W-1:0]  zero_space_ticks;
    logic [COUNT_W-1:0] entry_count;
  } cfg_regs_t;

endpackage

### src/irpd_if.sv
// Channel interfaces: input items, result items and register writes.
interface irpd_in_if;
  logic                          valid;
  logic                          ready;
  logic [irpd_pkg::CMD_W-1:0]    command;
  logic [irpd_pkg::SLOT_W-1:0]   entry_index;
  logic [irpd_pkg::DATA_W-1:0]   entry_data;
  logic [irpd_pkg::SIZE_W-1:0]   entry_size;

  modport source(output valid, command, entry_index, entry_data, entry_size, input ready);
  modport sink(input valid, command, entry_index, entry_data, entry_size, output ready);
endinterface

interface irpd_out_if;
  logic                          valid;
  logic                          ready;
  logic [irpd_pkg::TICK_W-1:0]   interval_ticks;
  logic [irpd_pkg::PHASE_W-1:0]  phase;
  logic                          finished;

  modport source(output valid, interval_ticks, phase, finished, input ready);
  modport sink(input valid, interval_ticks, phase, finished, output ready);
endinterface

interface irpd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [irpd_pkg::CFG_IDX_W-1:0] index;
  logic [irpd_pkg::TICK_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### src/irpd_seq.sv
// Frame sequencer: phase state, entry store and per-item result logic.
module irpd_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  irpd_pkg::item_t     item,
  input  logic                step,
  input  irpd_pkg::cfg_regs_t cfg,
  output logic                has_result,
  output irpd_pkg::result_t   result
);

  irpd_pkg::tx_state_t state_r, state_nxt;
  logic [irpd_pkg::POS_W-1:0]  entry_pos_r, entry_pos_nxt;
  logic [irpd_pkg::HALF_W-1:0] half_bit_pos_r, half_bit_pos_nxt;

  logic [irpd_pkg::DATA_W-1:0] entry_words [irpd_pkg::NUM_SLOTS];
  logic [irpd_pkg::SIZE_W-1:0] entry_lengths [irpd_pkg::NUM_SLOTS];

  logic [irpd_pkg::COUNT_W-1:0]   count_sat;
  logic [irpd_pkg::SLOT_W-1:0]    slot;
  logic [irpd_pkg::SIZE_W-1:0]    len_raw;
  logic [irpd_pkg::SIZE_W-1:0]    len_eff;
  logic [irpd_pkg::SIZE_W:0]      last_half;
  logic [irpd_pkg::BIT_SEL_W-1:0] bit_sel;
  logic                           cur_bit;

  always_comb begin
    count_sat = (cfg.entry_count > irpd_pkg::COUNT_W'(irpd_pkg::NUM_SLOTS))
              ? irpd_pkg::COUNT_W'(irpd_pkg::NUM_SLOTS) : cfg.entry_count;
    slot    = entry_pos_r[irpd_pkg::SLOT_W-1:0];
    len_raw = entry_lengths[slot];
    // Size zero sends one bit; oversize clamps to the word width.
    if (len_raw == '0) begin
      len_eff = irpd_pkg::SIZE_W'(1);
    end else if (len_raw > irpd_pkg::SIZE_W'(irpd_pkg::DATA_W)) begin
      len_eff = irpd_pkg::SIZE_W'(irpd_pkg::DATA_W);
    end else begin
      len_eff = len_raw;
    end
    last_half = {len_eff, 1'b0} - (irpd_pkg::SIZE_W+1)'(1);
    bit_sel   = half_bit_pos_r[irpd_pkg::BIT_SEL_W:1];
    cur_bit   = entry_words[slot][bit_sel];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= irpd_pkg::TX_IDLE;
      entry_pos_r    <= '0;
      half_bit_pos_r <= '0;
    end else if (step) begin
      state_r        <= state_nxt;
      entry_pos_r    <= entry_pos_nxt;
      half_bit_pos_r <= half_bit_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && item.command == irpd_pkg::CMD_LOAD) begin
      entry_words[item.entry_index]   <= item.entry_data;
      entry_lengths[item.entry_index] <= item.entry_size;
    end
  end

  always_comb begin
    state_nxt             = state_r;
    entry_pos_nxt         = entry_pos_r;
    half_bit_pos_nxt      = half_bit_pos_r;
    has_result            = 1'b0;
    result.interval_ticks = '0;
    result.phase          = irpd_pkg::PHASE_HEADER_SPACE;
    result.finished       = 1'b0;
    case (item.command)
      irpd_pkg::CMD_START: begin
        if (state_r == irpd_pkg::TX_IDLE || state_r == irpd_pkg::TX_COOLDOWN) begin
          state_nxt = irpd_pkg::TX_LEADER;
        end
      end
      irpd_pkg::CMD_EVENT: begin
        case (state_r)
          irpd_pkg::TX_LEADER: begin
            has_result            = 1'b1;
            result.interval_ticks = cfg.header_space_ticks;
            result.phase          = irpd_pkg::PHASE_HEADER_SPACE;
            state_nxt             = irpd_pkg::TX_DATA;
            entry_pos_nxt         = '0;
            half_bit_pos_nxt      = '0;
          end
          irpd_pkg::TX_DATA: begin
            has_result = 1'b1;
            if (entry_pos_r < count_sat) begin
              if (!half_bit_pos_r[0]) begin
                result.interval_ticks = cfg.mark_ticks;
                result.phase          = irpd_pkg::PHASE_BIT_MARK;
              end else if (cur_bit) begin
                result.interval_ticks = cfg.one_space_ticks;
                result.phase          = irpd_pkg::PHASE_ONE_SPACE;
              end else begin
                result.interval_ticks = cfg.zero_space_ticks;
                result.phase          = irpd_pkg::PHASE_ZERO_SPACE;
              end
              // Advance to the next entry after its last space.
              if ({1'b0, half_bit_pos_r} >= last_half) begin
                entry_pos_nxt    = entry_pos_r + irpd_pkg::POS_W'(1);
                half_bit_pos_nxt = '0;
              end else begin
                half_bit_pos_nxt = half_bit_pos_r + irpd_pkg::HALF_W'(1);
              end
            end else begin
              result.interval_ticks = cfg.mark_ticks;
              result.phase          = irpd_pkg::PHASE_TRAIL_MARK;
              state_nxt             = irpd_pkg::TX_END;
            end
          end
          irpd_pkg::TX_END: begin
            has_result      = 1'b1;
            result.phase    = irpd_pkg::PHASE_STOP;
            result.finished = 1'b1;
            state_nxt       = irpd_pkg::TX_COOLDOWN;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

### src/ir_pulse_distance_transmitter_top.sv
// Top level of the IR pulse-distance transmitter: input stage, sequencer, result stage.
// Each input item lands in an input register, the sequencer
// evaluates it there, and any result moves into an output register; a new item is
// accepted every cycle while the output register is free or being drained. Only a
// compare event during an active frame yields a result; load, start and events while
// idle or cooling down pass through silently. Registers are written through cfg_ch,
// which is always ready, and must only be written while the block is idle.
module ir_pulse_distance_transmitter_top (
  input  logic          clk,
  input  logic          rst_n,
  irpd_in_if.sink       in_ch,
  irpd_out_if.source    out_ch,
  irpd_cfg_if.sink      cfg_ch
);

  logic                s1_valid_r, s1_valid_nxt;
  irpd_pkg::item_t     s1_item_r;
  logic                out_valid_r, out_valid_nxt;
  irpd_pkg::result_t   out_result_r;
  irpd_pkg::cfg_regs_t cfg_r;

  logic              in_xfer;
  logic              s1_step;
  logic              seq_has_result;
  irpd_pkg::result_t seq_result;

  assign s1_step = s1_valid_r && (!seq_has_result || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_step;
  assign in_xfer = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_step) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_step && seq_has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.command     <= in_ch.command;
      s1_item_r.entry_index <= in_ch.entry_index;
      s1_item_r.entry_data  <= in_ch.entry_data;
      s1_item_r.entry_size  <= in_ch.entry_size;
    end
    if (s1_step && seq_has_result) begin
      out_result_r <= seq_result;
    end
  end

  irpd_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (s1_item_r),
    .step       (s1_step),
    .cfg        (cfg_r),
    .has_result (seq_has_result),
    .result     (seq_result)
  );

  assign out_ch.valid          = out_valid_r;
  assign out_ch.interval_ticks = out_result_r.interval_ticks;
  assign out_ch.phase          = out_result_r.phase;
  assign out_ch.finished       = out_result_r.finished;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_space_ticks <= irpd_pkg::RST_HEADER_SPACE;
      cfg_r.mark_ticks         <= irpd_pkg::RST_MARK;
      cfg_r.one_space_ticks    <= irpd_pkg::RST_ONE_SPACE;
      cfg_r.zero_space_ticks   <= irpd_pkg::RST_ZERO_SPACE;
      cfg_r.entry_count        <= irpd_pkg::RST_ENTRY_COUNT;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        irpd_pkg::REG_HEADER_SPACE: cfg_r.header_space_ticks <= cfg_ch.data;
        irpd_pkg::REG_MARK:         cfg_r.mark_ticks         <= cfg_ch.data;
        irpd_pkg::REG_ONE_SPACE:    cfg_r.one_space_ticks    <= cfg_ch.data;
        irpd_pkg::REG_ZERO_SPACE:   cfg_r.zero_space_ticks   <= cfg_ch.data;
        irpd_pkg::REG_ENTRY_COUNT:
          cfg_r.entry_count <= cfg_ch.data[irpd_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### src/irpd_checker.sv
// Port-level checks on the IR pulse-distance transmitter, bound to its top level.
module irpd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [irpd_pkg::TICK_W-1:0]  out_interval_ticks,
  input logic [irpd_pkg::PHASE_W-1:0] out_phase,
  input logic                         out_finished
);

  // A pending result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // Stop is the only finished result and carries no interval.
  a_stop_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_finished == (out_phase == irpd_pkg::PHASE_STOP)) &&
                  (!out_finished || out_interval_ticks == '0))
    else $error("malformed stop result");

  // Input stalls only behind a blocked result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // No result right out of reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind ir_pulse_distance_transmitter_top irpd_checker u_irpd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_interval_ticks (out_ch.interval_ticks),
  .out_phase          (out_ch.phase),
  .out_finished       (out_ch.finished)
);

### verif/tb_top.sv
// Testbench for the IR pulse-distance transmitter: directed and random frames against a local predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import irpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned RANDOM_TARGET = 650;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;
  localparam logic [CMD_W-1:0]  CMD_RESERVED = 2'd3;

  logic clk;
  logic rst_n;

  irpd_in_if  in_ch();
  irpd_out_if out_ch();
  irpd_cfg_if cfg_ch();

  ir_pulse_distance_transmitter_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predicted sequencer state and register copy
  cfg_regs_t         regs;
  tx_state_t         seq_state;
  logic [POS_W-1:0]  seq_entry;
  logic [HALF_W-1:0] seq_half;
  logic [DATA_W-1:0] slot_words [NUM_SLOTS];
  logic [SIZE_W-1:0] slot_sizes [NUM_SLOTS];
  result_t           pending_intervals [$];

  int unsigned cycle_count     = 0;
  int unsigned fail_count      = 0;
  int unsigned results_checked = 0;
  int unsigned effective_items = 0;
  int unsigned frames_done     = 0;
  int unsigned settings_done   = 0;
  bit          gaps_on         = 1'b1;
  bit          stalls_on       = 1'b1;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_intervals.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic result_t make_result(input logic [TICK_W-1:0] ticks,
                                          input logic [PHASE_W-1:0] ph,
                                          input logic fin);
    result_t r;
    r.interval_ticks = ticks;
    r.phase          = ph;
    r.finished       = fin;
    return r;
  endfunction

  function automatic item_t make_load(input logic [SLOT_W-1:0] slot,
                                      input logic [DATA_W-1:0] data,
                                      input logic [SIZE_W-1:0] size);
    item_t it;
    it.command     = CMD_LOAD;
    it.entry_index = slot;
    it.entry_data  = data;
    it.entry_size  = size;
    return it;
  endfunction

  // Non-load commands carry random junk in the unused fields.
  function automatic item_t make_cmd(input logic [CMD_W-1:0] cmd);
    item_t it;
    it.command     = cmd;
    it.entry_index = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    it.entry_data  = DATA_W'($urandom());
    it.entry_size  = SIZE_W'($urandom_range(0, 63));
    return it;
  endfunction

  function automatic item_t random_load();
    logic [DATA_W-1:0] data;
    logic [SIZE_W-1:0] size;
    int unsigned r;
    r = $urandom_range(0, 9);
    data = (r == 0) ? '0 : (r == 1) ? '1 : DATA_W'($urandom());
    r = $urandom_range(0, 99);
    if (r < 65) size = SIZE_W'($urandom_range(0, 4));
    else if (r < 90) size = SIZE_W'($urandom_range(5, 32));
    else size = SIZE_W'($urandom_range(33, 63));
    return make_load(SLOT_W'($urandom_range(0, NUM_SLOTS - 1)), data, size);
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it = make_cmd(CMD_W'($urandom_range(0, 3)));
    return it;
  endfunction

  function automatic logic [TICK_W-1:0] random_ticks();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return TICK_MAX;
    return TICK_W'($urandom_range(0, 65535));
  endfunction

  // Advance the predicted sequencer by one accepted transfer.
  task automatic predict_intervals(input item_t it);
    int unsigned       active_count;
    int unsigned       bits;
    logic [SLOT_W-1:0] slot;
    case (it.command)
      CMD_LOAD: begin
        slot_words[it.entry_index] = it.entry_data;
        slot_sizes[it.entry_index] = it.entry_size;
        effective_items++;
      end
      CMD_START: begin
        if (seq_state == TX_IDLE || seq_state == TX_COOLDOWN) begin
          seq_state = TX_LEADER;
          effective_items++;
        end
      end
      CMD_EVENT: begin
        case (seq_state)
          TX_LEADER: begin
            pending_intervals.push_back(make_result(regs.header_space_ticks,
                                                    PHASE_HEADER_SPACE, 1'b0));
            seq_state = TX_DATA;
            seq_entry = '0;
            seq_half  = '0;
            effective_items++;
          end
          TX_DATA: begin
            active_count = (regs.entry_count > NUM_SLOTS) ? NUM_SLOTS : regs.entry_count;
            if (seq_entry < active_count) begin
              slot = seq_entry[SLOT_W-1:0];
              bits = slot_sizes[slot];
              // zero size still sends one bit; oversize clamps to the word
              if (bits == 0) bits = 1;
              if (bits > DATA_W) bits = DATA_W;
              if (!seq_half[0])
                pending_intervals.push_back(make_result(regs.mark_ticks,
                                                        PHASE_BIT_MARK, 1'b0));
              else if (slot_words[slot][seq_half[HALF_W-1:1]])
                pending_intervals.push_back(make_result(regs.one_space_ticks,
                                                        PHASE_ONE_SPACE, 1'b0));
              else
                pending_intervals.push_back(make_result(regs.zero_space_ticks,
                                                        PHASE_ZERO_SPACE, 1'b0));
              if (seq_half >= 2 * bits - 1) begin
                seq_entry++;
                seq_half = '0;
              end else begin
                seq_half++;
              end
            end else begin
              pending_intervals.push_back(make_result(regs.mark_ticks,
                                                      PHASE_TRAIL_MARK, 1'b0));
              seq_state = TX_END;
            end
            effective_items++;
          end
          TX_END: begin
            pending_intervals.push_back(make_result('0, PHASE_STOP, 1'b1));
            seq_state = TX_COOLDOWN;
            effective_items++;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input item_t it);
    int unsigned gap;
    int unsigned r;
    gap = 0;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(12, 40);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= it.command;
    in_ch.entry_index <= it.entry_index;
    in_ch.entry_data  <= it.entry_data;
    in_ch.entry_size  <= it.entry_size;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_intervals(it);
  endtask

  // Hold the input side until every predicted result is back, then let the pipe settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_intervals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_HEADER_SPACE: regs.header_space_ticks = value;
      REG_MARK:         regs.mark_ticks         = value;
      REG_ONE_SPACE:    regs.one_space_ticks    = value;
      REG_ZERO_SPACE:   regs.zero_space_ticks   = value;
      REG_ENTRY_COUNT:  regs.entry_count        = value[COUNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [TICK_W-1:0] hdr_gap,
                          input logic [TICK_W-1:0] mark,
                          input logic [TICK_W-1:0] one_space,
                          input logic [TICK_W-1:0] zero_space,
                          input logic [TICK_W-1:0] count_word);
    wait_drained();
    write_reg(REG_HEADER_SPACE, hdr_gap);
    write_reg(REG_MARK, mark);
    write_reg(REG_ONE_SPACE, one_space);
    write_reg(REG_ZERO_SPACE, zero_space);
    write_reg(REG_ENTRY_COUNT, count_word);
    settings_done++;
  endtask

  // One well-formed frame with random content, sprinkled with loads and stray commands.
  task automatic run_frame(input bit pause_mid);
    int unsigned n;
    int unsigned r;
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) send_item(random_load());
    send_item(make_cmd(CMD_START));
    n = 0;
    while (seq_state != TX_COOLDOWN) begin
      r = $urandom_range(0, 19);
      if (r == 0) send_item(random_load());
      else if (r == 1) send_item(noise_item());
      else send_item(make_cmd(CMD_EVENT));
      n++;
      if (pause_mid && n == 3) wait_drained();
    end
    if ($urandom_range(0, 3) == 0) send_item(make_cmd(CMD_EVENT));
    frames_done++;
  endtask

  task automatic test_reset_defaults();
    send_item(make_cmd(CMD_EVENT));     // idle: no result
    send_item(make_cmd(CMD_RESERVED));  // unknown command
    send_item(make_cmd(CMD_START));
    repeat (3) send_item(make_cmd(CMD_EVENT));
    send_item(make_cmd(CMD_EVENT));     // cooldown: no result
    frames_done++;
    wait_drained();
  endtask

  task automatic test_corner_entries();
    set_regs(16'd1000, 16'd20, 16'd300, 16'd4, 16'd2);
    send_item(make_load(3'd0, 32'hFFFF_FFFF, 6'd0));
    send_item(make_load(3'd1, 32'h0000_0000, 6'd1));
    send_item(make_load(3'd2, 32'hAAAA_5555, 6'd32));
    send_item(make_load(3'd3, 32'h0000_0000, 6'd63));
    send_item(make_load(3'd4, 32'hFFFF_FFFF, 6'd1));
    send_item(make_load(3'd5, 32'h1234_5678, 6'd33));
    send_item(make_load(3'd6, 32'h0000_0000, 6'd2));
    send_item(make_load(3'd7, 32'h8000_0001, 6'd32));
    send_item(make_cmd(CMD_START));
    send_item(make_cmd(CMD_START));     // ignored: frame already armed
    repeat (3) send_item(make_cmd(CMD_EVENT));
    // reload slot 1 mid-frame, before it is read
    send_item(make_load(3'd1, 32'hFFFF_FFFE, 6'd2));
    repeat (7) send_item(make_cmd(CMD_EVENT));
    frames_done++;
    wait_drained();
  endtask

  task automatic test_register_extremes();
    for (int s = 0; s < NUM_SLOTS; s++)
      send_item(make_load(SLOT_W'(s), DATA_W'($urandom()), SIZE_W'($urandom_range(0, 3))));
    set_regs('0, '0, '0, '0, 16'd15);
    run_frame(1'b0);
    set_regs(TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX, 16'(NUM_SLOTS));
    run_frame(1'b0);
    set_regs(TICK_MAX, '0, TICK_MAX, '0, 16'd1);
    run_frame(1'b0);
    set_regs(random_ticks(), random_ticks(), random_ticks(), random_ticks(), 16'd0);
    run_frame(1'b0);
  endtask

  task automatic test_random_traffic();
    int unsigned       stop_at;
    int unsigned       phase_end;
    int unsigned       r;
    logic [1:0]        mode;
    logic [COUNT_W-1:0] count;
    bit                first;
    stop_at = effective_items + RANDOM_TARGET;
    first = 1'b1;
    while (effective_items < stop_at) begin
      r = $urandom_range(0, 9);
      if (r == 0) count = '0;
      else if (r == 1) count = COUNT_W'(NUM_SLOTS);
      else if (r == 2) count = COUNT_W'($urandom_range(NUM_SLOTS + 1, 15));
      else count = COUNT_W'($urandom_range(1, 4));
      set_regs(random_ticks(), random_ticks(), random_ticks(), random_ticks(),
               {12'($urandom()), count});
      // both quiet, sender gaps only, receiver stalls only, or both
      mode = 2'($urandom_range(0, 3));
      gaps_on   = mode[0];
      stalls_on = mode[1];
      phase_end = effective_items + $urandom_range(60, 140);
      while (effective_items < phase_end && effective_items < stop_at) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 6)) send_item(noise_item());
        end else begin
          run_frame(first);
          first = 1'b0;
        end
      end
    end
  endtask

  // Result receiver with random backpressure.
  initial begin
    int unsigned hold;
    bit          level;
    hold  = 0;
    level = 1'b1;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!stalls_on) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (hold == 0) begin
          level = ($urandom_range(0, 99) < 65);
          if (level) hold = $urandom_range(1, 8);
          else if ($urandom_range(0, 4) == 0) hold = $urandom_range(12, 40);
          else hold = $urandom_range(1, 3);
        end
        hold--;
        out_ch.ready <= level;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_intervals.size() == 0) begin
        $error("result transfer with nothing expected: interval_ticks %0d phase %0d finished %0b",
               out_ch.interval_ticks, out_ch.phase, out_ch.finished);
        fail_count++;
      end else begin
        want = pending_intervals.pop_front();
        results_checked++;
        if (out_ch.interval_ticks !== want.interval_ticks) begin
          $error("interval_ticks: expected %0d, got %0d", want.interval_ticks,
                 out_ch.interval_ticks);
          fail_count++;
        end
        if (out_ch.phase !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, out_ch.phase);
          fail_count++;
        end
        if (out_ch.finished !== want.finished) begin
          $error("finished: expected %0b, got %0b", want.finished, out_ch.finished);
          fail_count++;
        end
      end
    end
  end

  initial begin
    clk   = 1'b0;
    rst_n = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_LOAD;
    in_ch.entry_index = '0;
    in_ch.entry_data  = '0;
    in_ch.entry_size  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_HEADER_SPACE;
    cfg_ch.data  = '0;
    regs.header_space_ticks = RST_HEADER_SPACE;
    regs.mark_ticks         = RST_MARK;
    regs.one_space_ticks    = RST_ONE_SPACE;
    regs.zero_space_ticks   = RST_ZERO_SPACE;
    regs.entry_count        = RST_ENTRY_COUNT;
    seq_state = TX_IDLE;
    seq_entry = '0;
    seq_half  = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      slot_words[s] = '0;
      slot_sizes[s] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_corner_entries();
    test_register_extremes();
    test_random_traffic();
    wait_drained();

    $display("Ran %0d frames under %0d register settings: %0d effective input transfers,",
             frames_done, settings_done, effective_items);
    $display("%0d result transfers checked in %0d cycles.", results_checked, cycle_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
